[sv/spm_pkg.sv]
package spm_pkg;

	localparam logic [63:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
	localparam int unsigned MIX_SHIFT_A = 30;
	localparam int unsigned MIX_SHIFT_B = 27;
	localparam int unsigned MIX_SHIFT_C = 31;

	localparam int unsigned DIGIT_W = 16;
	localparam int unsigned DIV_STEPS = 64;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_ADVANCE,
		OP_XOR_A,
		OP_MUL_A,
		OP_XOR_B,
		OP_MUL_B,
		OP_XOR_C,
		OP_DIV
	} dp_op_t;

	typedef enum logic [1:0] {
		OUT_MIX,
		OUT_REM,
		OUT_ZERO
	} out_sel_t;

	typedef struct packed {
		logic     seed_load;
		dp_op_t   op;
		logic [1:0] digit;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic bound_zero;
	} sts_t;

	function automatic logic [DIGIT_W-1:0] mul_digit(input logic [63:0] mult,
		input logic [1:0] idx);
		logic [63:0] shifted;
		shifted = mult >> {idx, 4'b0000};
		return shifted[DIGIT_W-1:0];
	endfunction

endpackage

[sv/spm_datapath.sv]
module spm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  spm_pkg::cmd_t       cmd,
	output spm_pkg::sts_t       sts,
	input  logic [63:0]         seed_value,
	input  logic                func,
	input  logic [63:0]         upper_bound,
	output logic [63:0]         random_value
);

	logic [63:0] state_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic [63:0] bound_q;
	logic        func_q;
	logic [63:0] out_q;

	logic [63:0] state_inc;
	logic [15:0] digit;
	logic [63:0] prod;
	logic [64:0] trial;
	logic [64:0] trial_sub;

	assign state_inc = state_q + spm_pkg::GOLDEN_INC;
	assign digit = (cmd.op == spm_pkg::OP_MUL_B) ?
		spm_pkg::mul_digit(spm_pkg::MIX_MUL_B, cmd.digit) :
		spm_pkg::mul_digit(spm_pkg::MIX_MUL_A, cmd.digit);
	assign prod = x_q * 64'(digit);
	assign trial = {rem_q, x_q[63]};
	assign trial_sub = trial - {1'b0, bound_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.seed_load) begin
			state_q <= seed_value;
		end else if (cmd.op == spm_pkg::OP_ADVANCE) begin
			state_q <= state_inc;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			spm_pkg::OP_CAPTURE: begin
				func_q  <= func;
				bound_q <= upper_bound;
			end
			spm_pkg::OP_ADVANCE: begin
				x_q <= state_inc;
			end
			spm_pkg::OP_XOR_A: begin
				x_q   <= x_q ^ (x_q >> spm_pkg::MIX_SHIFT_A);
				acc_q <= '0;
			end
			spm_pkg::OP_MUL_A, spm_pkg::OP_MUL_B: begin
				acc_q <= acc_q + prod;
				x_q   <= x_q << spm_pkg::DIGIT_W;
			end
			spm_pkg::OP_XOR_B: begin
				x_q   <= acc_q ^ (acc_q >> spm_pkg::MIX_SHIFT_B);
				acc_q <= '0;
			end
			spm_pkg::OP_XOR_C: begin
				x_q   <= acc_q ^ (acc_q >> spm_pkg::MIX_SHIFT_C);
				rem_q <= '0;
			end
			spm_pkg::OP_DIV: begin
				rem_q <= trial_sub[64] ? trial[63:0] : trial_sub[63:0];
				x_q   <= x_q << 1;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			case (cmd.out_sel)
				spm_pkg::OUT_MIX: out_q <= x_q;
				spm_pkg::OUT_REM: out_q <= rem_q;
				default:          out_q <= '0;
			endcase
		end
	end

	assign sts.func       = func_q;
	assign sts.bound_zero = (bound_q == '0);
	assign random_value   = out_q;

endmodule

[sv/spm_controller.sv]
module spm_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  spm_pkg::sts_t sts,
	output spm_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ADV,
		ST_XOR_A,
		ST_MUL_A,
		ST_XOR_B,
		ST_MUL_B,
		ST_XOR_C,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.seed_load = cfg_valid && cfg_ready;
		cmd.op        = spm_pkg::OP_NONE;
		cmd.digit     = cnt_q[1:0];
		cmd.out_load  = 1'b0;
		cmd.out_sel   = spm_pkg::OUT_MIX;
		if (sts.func && sts.bound_zero) begin
			cmd.out_sel = spm_pkg::OUT_ZERO;
		end else if (sts.func) begin
			cmd.out_sel = spm_pkg::OUT_REM;
		end
		case (state_q)
			ST_IDLE:  if (in_valid) cmd.op = spm_pkg::OP_CAPTURE;
			ST_ADV:   cmd.op = spm_pkg::OP_ADVANCE;
			ST_XOR_A: cmd.op = spm_pkg::OP_XOR_A;
			ST_MUL_A: cmd.op = spm_pkg::OP_MUL_A;
			ST_XOR_B: cmd.op = spm_pkg::OP_XOR_B;
			ST_MUL_B: cmd.op = spm_pkg::OP_MUL_B;
			ST_XOR_C: cmd.op = spm_pkg::OP_XOR_C;
			ST_DIV:   cmd.op = spm_pkg::OP_DIV;
			ST_FIN:   cmd.out_load = out_free;
			default:  cmd.op = spm_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || cmd.out_load;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CHECK;
				ST_CHECK: begin
					state_q <= (sts.func && sts.bound_zero) ? ST_FIN : ST_ADV;
				end
				ST_ADV: state_q <= ST_XOR_A;
				ST_XOR_A: begin
					cnt_q   <= '0;
					state_q <= ST_MUL_A;
				end
				ST_MUL_A: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) state_q <= ST_XOR_B;
				end
				ST_XOR_B: begin
					cnt_q   <= '0;
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) state_q <= ST_XOR_C;
				end
				ST_XOR_C: begin
					cnt_q   <= '0;
					state_q <= sts.func ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(spm_pkg::DIV_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/splitmix64_random_generator_core.sv]
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   seed_value[63:0]
// in       in         in_valid/in_ready     func, upper_bound[63:0]
// out      out        out_valid/out_ready   random_value[63:0]
//
// A bounded request with a zero bound skips the mix and returns zero; a raw request
// runs the advance, the xor-shift steps and the two 16-bit digit multiply rounds; a
// bounded request then runs the restoring remainder loop one bit per cycle.
// One request is in work at a time; the next beat is taken once the result is in the
// output register, and the output register holds while out_ready is low.
// Reset clears the generator state to zero; a seed beat reloads it.
module splitmix64_random_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed_value,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] upper_bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] random_value
);

	spm_pkg::cmd_t cmd;
	spm_pkg::sts_t sts;

	spm_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	spm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.seed_value   (seed_value),
		.func         (func),
		.upper_bound  (upper_bound),
		.random_value (random_value)
	);

endmodule

[sv/spm_checker.sv]
module spm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        func,
	input logic [63:0] upper_bound,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] random_value
);

	// hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value))
		else $error("stalled result changed");

	// drop ready once a request beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !cfg_ready)
		else $error("second beat taken while busy");

	// zero bound gives zero quickly
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func && (upper_bound == 64'd0) && !out_valid
		|-> ##3 out_valid && (random_value == 64'd0))
		else $error("zero bound result wrong");

	// take a seed beat only while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> in_ready)
		else $error("seed beat taken while busy");

endmodule

bind splitmix64_random_generator_core spm_checker u_chk (.*);
